@@ design/mhp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhp_pkg
// Shared types and constants of the MQTT header parser: parse phases, status
// codes, parser state and header record layouts.
// ----------------------------------------------------------------------------
package mhp_pkg;

	localparam int MAX_VARINT_BYTES = 4;

	// parse phases
	localparam logic [2:0] PH_IDLE       = 3'd0;
	localparam logic [2:0] PH_VARINT     = 3'd1;
	localparam logic [2:0] PH_TOPIC_HI   = 3'd2;
	localparam logic [2:0] PH_TOPIC_LO   = 3'd3;
	localparam logic [2:0] PH_TOPIC_SKIP = 3'd4;
	localparam logic [2:0] PH_ID_HI      = 3'd5;
	localparam logic [2:0] PH_ID_LO      = 3'd6;
	localparam logic [2:0] PH_BODY       = 3'd7;

	// record status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_VARINT  = 2'd1;
	localparam logic [1:0] ST_OVERRUN = 2'd2;

	localparam logic [3:0] PKT_PUBLISH = 4'd3;

	localparam int DATA_W = 128;
	localparam int USER_W = 3;

	typedef struct packed {
		logic [2:0]  phase;
		logic [7:0]  first_byte;
		logic [2:0]  varint_count;
		logic [27:0] remaining_value;
		logic [27:0] bytes_left;
		logic [15:0] topic_len;
		logic [15:0] id;         // topic skip countdown, then packet id
	} st_t;

	typedef struct packed {
		logic [3:0]  packet_type;
		logic        dup;
		logic [1:0]  qos;
		logic        retain;
		logic [27:0] remaining_length;
		logic [28:0] total_length;
		logic [15:0] topic_length;
		logic [15:0] packet_id;
		logic [27:0] payload_length;
		logic        is_publish;
		logic [1:0]  status;
	} rec_t;

endpackage

@@ design/mqtt_header_parser_core.sv @@
`timescale 1ns / 1ps
// Record path: the byte completing the header is taken into the input register,
//   and its record is then loaded into the result register, which drives m_tvalid
//   (that load waits while the result register still holds a stalled record).
// Throughput: one byte per cycle; the byte path stalls only while a finished
//   record waits in the result register and the sink holds m_tready low.
// Reset: arst_n clears the parser to wait for a first byte and empties both registers.
// ----------------------------------------------------------------------------
// mqtt_header_parser_core
// Parses back-to-back MQTT control packets one byte per transfer and emits one
// header record per packet (fixed header, plus topic length, packet id and
// payload length for PUBLISH).
// ----------------------------------------------------------------------------
module mqtt_header_parser_core import mhp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// byte stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] byte_in
	input  logic [0:0]        s_tuser,   // [0] frame_start
	// header records
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [3:0] packet_type, [4] dup, [6:5] qos,
	                                     // [7] retain, [35:8] remaining_length,
	                                     // [64:36] total_length, [80:65] topic_length,
	                                     // [96:81] packet_id, [124:97] payload_length
	output logic [USER_W-1:0] m_tuser    // [0] is_publish, [2:1] status
);

	// input register stage
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// parser state, advanced once per consumed byte
	st_t  st_q;
	st_t  st_nxt;
	rec_t rec;
	logic rec_vld;
	logic out_free;
	logic adv;

	// A byte leaves stage 1 whenever the result register can take a record.
	// Bytes that complete no header could go regardless, but tying advance to
	// out_free keeps ordering trivially correct.
	assign adv      = vld_s1 && out_free;
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser[0];
		end
	end

	// whole parser state is control: reset to idle with cleared counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	mhp_step u_step (
		.st          (st_q),
		.byte_in     (byte_s1),
		.frame_start (start_s1),
		.st_nxt      (st_nxt),
		.rec         (rec),
		.rec_vld     (rec_vld)
	);

	// record lands here on the step that completes the header or flags an error
	mhp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv && rec_vld),
		.rec      (rec),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

@@ design/mhp_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhp_step
// Per-byte parse logic: next parser state and the header record, if any.
// ----------------------------------------------------------------------------
module mhp_step import mhp_pkg::*; (
	input  st_t        st,
	input  logic [7:0] byte_in,
	input  logic       frame_start,
	output st_t        st_nxt,
	output rec_t       rec,
	output logic       rec_vld
);

	logic [27:0] shifted;
	logic [27:0] rv_acc;
	logic [27:0] bl_dec;
	logic [2:0]  cnt_inc;
	logic [15:0] tl_new;
	logic [15:0] id_dec;
	logic [16:0] need;
	logic        qos_nz;
	logic        pub;

	always_comb begin
		case (st.varint_count)
			3'd0:    shifted = {21'd0, byte_in[6:0]};
			3'd1:    shifted = {14'd0, byte_in[6:0], 7'd0};
			3'd2:    shifted = {7'd0, byte_in[6:0], 14'd0};
			3'd3:    shifted = {byte_in[6:0], 21'd0};
			default: shifted = '0;
		endcase
	end

	assign rv_acc  = st.remaining_value | shifted;
	assign bl_dec  = st.bytes_left - 28'd1;
	assign cnt_inc = st.varint_count + 3'd1;
	assign tl_new  = {st.topic_len[15:8], byte_in};
	assign id_dec  = st.id - 16'd1;
	assign qos_nz  = |st.first_byte[2:1];
	assign pub     = (st.first_byte[7:4] == PKT_PUBLISH);
	assign need    = {1'b0, tl_new} + (qos_nz ? 17'd2 : 17'd0);

	always_comb begin
		st_nxt  = st;
		rec_vld = 1'b0;
		rec     = '0;
		rec.packet_type      = st.first_byte[7:4];
		rec.dup              = st.first_byte[3];
		rec.qos              = st.first_byte[2:1];
		rec.retain           = st.first_byte[0];
		rec.is_publish       = pub;
		rec.remaining_length = st.remaining_value;
		rec.total_length     = 29'd1 + {26'd0, st.varint_count} + {1'b0, st.remaining_value};
		rec.status           = ST_OK;

		if (frame_start || st.phase == PH_IDLE) begin
			st_nxt            = '0;
			st_nxt.first_byte = byte_in;
			st_nxt.phase      = PH_VARINT;
		end else begin
			case (st.phase)
				PH_VARINT: begin
					st_nxt.remaining_value = rv_acc;
					st_nxt.varint_count    = cnt_inc;
					rec.remaining_length   = rv_acc;
					if (byte_in[7]) begin
						rec.total_length = '0;
						if (cnt_inc >= 3'(MAX_VARINT_BYTES)) begin
							rec_vld      = 1'b1;
							rec.status   = ST_VARINT;
							st_nxt.phase = PH_IDLE;
						end
					end else begin
						st_nxt.bytes_left = rv_acc;
						rec.total_length  = 29'd1 + {26'd0, cnt_inc} + {1'b0, rv_acc};
						if (!pub || rv_acc < 28'd2) begin
							rec_vld      = 1'b1;
							rec.status   = pub ? ST_OVERRUN : ST_OK;
							st_nxt.phase = (rv_acc != '0) ? PH_BODY : PH_IDLE;
						end else begin
							st_nxt.phase = PH_TOPIC_HI;
						end
					end
				end
				PH_TOPIC_HI: begin
					st_nxt.bytes_left = bl_dec;
					st_nxt.topic_len  = {byte_in, 8'd0};
					st_nxt.phase      = PH_TOPIC_LO;
				end
				PH_TOPIC_LO: begin
					st_nxt.bytes_left = bl_dec;
					st_nxt.topic_len  = tl_new;
					rec.topic_length  = tl_new;
					if ({11'd0, need} > bl_dec) begin
						rec_vld      = 1'b1;
						rec.status   = ST_OVERRUN;
						st_nxt.phase = (bl_dec != '0) ? PH_BODY : PH_IDLE;
					end else if (tl_new != '0) begin
						st_nxt.id    = tl_new;
						st_nxt.phase = PH_TOPIC_SKIP;
					end else if (qos_nz) begin
						st_nxt.phase = PH_ID_HI;
					end else begin
						rec_vld            = 1'b1;
						rec.payload_length = bl_dec;
						st_nxt.phase       = (bl_dec != '0) ? PH_BODY : PH_IDLE;
					end
				end
				PH_TOPIC_SKIP: begin
					st_nxt.bytes_left = bl_dec;
					st_nxt.id         = id_dec;
					rec.topic_length  = st.topic_len;
					if (id_dec == '0) begin
						if (qos_nz) begin
							st_nxt.phase = PH_ID_HI;
						end else begin
							rec_vld            = 1'b1;
							rec.payload_length = bl_dec;
							st_nxt.phase       = (bl_dec != '0) ? PH_BODY : PH_IDLE;
						end
					end
				end
				PH_ID_HI: begin
					st_nxt.bytes_left = bl_dec;
					st_nxt.id         = {byte_in, 8'd0};
					st_nxt.phase      = PH_ID_LO;
				end
				PH_ID_LO: begin
					st_nxt.bytes_left  = bl_dec;
					st_nxt.id          = {st.id[15:8], byte_in};
					rec_vld            = 1'b1;
					rec.topic_length   = st.topic_len;
					rec.packet_id      = {st.id[15:8], byte_in};
					rec.payload_length = bl_dec;
					st_nxt.phase       = (bl_dec != '0) ? PH_BODY : PH_IDLE;
				end
				PH_BODY: begin
					st_nxt.bytes_left = bl_dec;
					if (bl_dec == '0) begin
						st_nxt.phase = PH_IDLE;
					end
				end
				default: begin
					st_nxt.phase = PH_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/mhp_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhp_out_reg
// Result register: holds one header record until the sink takes it.
// ----------------------------------------------------------------------------
module mhp_out_reg import mhp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  rec_t              rec,
	output logic              free,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,
	output logic [USER_W-1:0] m_tuser
);

	logic vld_q;
	rec_t rec_q;

	assign free = !vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (free) begin
			vld_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			rec_q <= rec;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {3'd0, rec_q.payload_length, rec_q.packet_id, rec_q.topic_length,
		rec_q.total_length, rec_q.remaining_length, rec_q.retain, rec_q.qos,
		rec_q.dup, rec_q.packet_type};
	assign m_tuser  = {rec_q.status, rec_q.is_publish};

endmodule

@@ design/mhp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhp_checker
// Port-level checks of the header parser, bound to the top level.
// ----------------------------------------------------------------------------
module mhp_checker import mhp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata,
	input logic [USER_W-1:0] m_tuser
);

	// stalled record holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("record changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[2:1] == ST_OK || m_tuser[2:1] == ST_VARINT
			|| m_tuser[2:1] == ST_OVERRUN)
		else $error("bad status code");

	a_pub: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[0] == (m_tdata[3:0] == PKT_PUBLISH))
		else $error("is_publish disagrees with packet type");

	a_nonpub: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[124:65] == '0)
		else $error("publish fields set on non-publish record");

	a_varint: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:1] == ST_VARINT |-> m_tdata[124:36] == '0)
		else $error("length fields set on varint error record");

endmodule

bind mqtt_header_parser_core mhp_checker u_mhp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
